// ===== design/x86_64_modrm_sib_rex_encoder_core_macros.svh =====
// Assertion macros for the operand encoder.
// Each macro expects clk and rst_n in scope at the point of use.
`ifndef X86_64_MODRM_SIB_REX_ENCODER_CORE_MACROS_SVH
`define X86_64_MODRM_SIB_REX_ENCODER_CORE_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, checked out of reset
`define X86ENC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define X86ENC_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define X86ENC_ASSERT_IMP(label, ante, cons, msg)
`define X86ENC_ASSERT_NXT(label, ante, cons, msg)

`endif

`endif

// ===== design/x86enc_pkg.sv =====
package x86enc_pkg;

    // Error codes of a result word
    typedef logic [2:0] err_t;
    localparam err_t ERR_OK        = 3'd0;
    localparam err_t ERR_SCALE     = 3'd1;
    localparam err_t ERR_NOT_MEM   = 3'd2;
    localparam err_t ERR_RIP_INDEX = 3'd3;
    localparam err_t ERR_RSP_INDEX = 3'd4;
    localparam err_t ERR_TYPE      = 3'd5;
    localparam err_t ERR_REX       = 3'd6;
    localparam err_t ERR_NO_BASE   = 3'd7;

    // Operand forms
    localparam logic FORM_REG = 1'b0;
    localparam logic FORM_MEM = 1'b1;

    // Displacement size codes
    typedef logic [1:0] disp_t;
    localparam disp_t DISP_NONE = 2'd0;
    localparam disp_t DISP_8    = 2'd1;
    localparam disp_t DISP_32   = 2'd2;

    // Register type: 3-bit class from the table, or none for codes outside it
    typedef logic [3:0] reg_type_t;
    localparam reg_type_t TYPE_NONE  = 4'hF;
    localparam reg_type_t TYPE_QWORD = 4'd3;

    localparam logic [7:0] MODRM_DIRECT = 8'hC0;
    localparam logic [6:0] REX_BASE     = 7'h40;
    localparam logic [2:0] RM_SIB       = 3'h4;
    localparam logic [2:0] RM_DISP      = 3'h5;
    localparam logic [2:0] SIB_NO_INDEX = 3'h4;
    localparam logic [7:0] LAST_CODE    = 8'd135;

    // Decoded attributes of one register code
    typedef struct packed {
        logic [2:0] low3;
        logic       rex_bit;
        reg_type_t  typ;
        logic       mem_ok;
        logic       always_rex;
        logic       never_rex;
        logic       is_none;
        logic       is_rip;
        logic       is_sp_idx;
    } reg_attr_t;

    // One encoded result word
    typedef struct packed {
        err_t       error_code;
        logic [7:0] modrm_byte;
        logic       sib_present;
        logic [7:0] sib_byte;
        logic       rex_present;
        logic [6:0] rex_byte;
        disp_t      disp_bytes_code;
    } enc_result_t;

    // Register attribute table, one row of eight codes per case arm
    function automatic logic [4:0] rom_attr(input logic [7:0] code);
        logic [4:0] a;
        case (code[7:3])
            5'd0:    a = 5'd1;
            5'd1:    a = code[2] ? 5'd1 : 5'd0;
            5'd2:    a = 5'd2;
            5'd3:    a = 5'd5;
            5'd4:    a = 5'd6;
            5'd5:    a = 5'd9;
            5'd6:    a = 5'd10;
            5'd7:    a = 5'd13;
            5'd8:    a = 5'd14;
            5'd9:    a = 5'd19;
            5'd10:   a = 5'd21;
            5'd11:   a = 5'd22;
            5'd12:   a = (code[2:1] == 2'b11) ? 5'd0 : 5'd27;
            5'd13:   a = 5'd29;
            5'd14:   a = 5'd30;
            5'd15:   a = 5'd29;
            5'd16:   a = (code[2:1] == 2'b00) ? 5'd30 : 5'd0;
            default: a = 5'd0;
        endcase
        return a;
    endfunction

endpackage

// ===== design/x86enc_attr.sv =====
module x86enc_attr (
    input  logic signed [8:0]      code,
    output x86enc_pkg::reg_attr_t  attr
);
    import x86enc_pkg::*;

    logic       in_range;
    logic [4:0] rom;

    // Look up the table for codes in range
    assign in_range = !code[8] && (code[7:0] <= LAST_CODE);
    assign rom      = in_range ? rom_attr(code[7:0]) : 5'd0;

    // Decode attributes
    always_comb
    begin
        attr.low3       = code[2:0];
        attr.rex_bit    = in_range && (rom[1:0] == 2'd2);
        attr.typ        = in_range ? {1'b0, rom[4:2]} : TYPE_NONE;
        attr.mem_ok     = !code[8] && (code[7:0] >= 8'd40) && (code[7:0] <= 8'd71);
        attr.always_rex = !code[8] && (code[7:0] >= 8'd12) && (code[7:0] <= 8'd15);
        attr.never_rex  = !code[8] && (code[7:0] >= 8'd4) && (code[7:0] <= 8'd7);
        attr.is_none    = (code == -9'sd1);
        attr.is_rip     = (code == -9'sd2);
        attr.is_sp_idx  = (code == 9'sd44) || (code == 9'sd60);
    end

endmodule

// ===== design/x86enc_encode.sv =====
module x86enc_encode (
    input  logic                    opcode,
    input  x86enc_pkg::reg_attr_t   reg_a,
    input  x86enc_pkg::reg_attr_t   rm_a,
    input  x86enc_pkg::reg_attr_t   idx_a,
    input  logic [7:0]              scale_multiplier,
    input  logic signed [31:0]      displacement,
    output x86enc_pkg::enc_result_t result
);
    import x86enc_pkg::*;

    logic       need_sib;
    logic       ss_ok;
    logic [1:0] ss;
    disp_t      dsz;
    disp_t      dcode_mem;
    logic       w;
    logic       r;
    logic       x;
    logic       b;
    logic       rex;
    err_t       err;
    logic [7:0] modrm;
    logic       sibp;
    logic [7:0] sib;
    disp_t      dcode;

    // Scale to SIB ss field
    always_comb
    begin
        ss_ok = 1'b1;
        case (scale_multiplier)
            8'd1:    ss = 2'd0;
            8'd2:    ss = 2'd1;
            8'd4:    ss = 2'd2;
            8'd8:    ss = 2'd3;
            default:
            begin
                ss    = 2'd0;
                ss_ok = 1'b0;
            end
        endcase
    end

    // Size the displacement; a disp-coded base always needs at least disp8
    always_comb
    begin
        if (displacement == 32'sd0)
            dsz = DISP_NONE;
        else if ((&displacement[31:7]) || !(|displacement[31:7]))
            dsz = DISP_8;
        else
            dsz = DISP_32;
        dcode_mem = (dsz == DISP_NONE && rm_a.low3 == RM_DISP) ? DISP_8 : dsz;
    end

    assign need_sib = (scale_multiplier != 8'd1) || !idx_a.is_none || (rm_a.low3 == RM_SIB);

    // Encode one operand
    always_comb
    begin
        err   = ERR_OK;
        modrm = 8'd0;
        sibp  = 1'b0;
        sib   = 8'd0;
        dcode = DISP_NONE;
        x     = 1'b0;
        r     = reg_a.rex_bit;
        b     = rm_a.rex_bit;
        if (opcode == FORM_REG)
        begin
            modrm = MODRM_DIRECT | {2'b00, reg_a.low3, rm_a.low3};
            w     = (reg_a.typ == TYPE_QWORD) || (rm_a.typ == TYPE_QWORD);
            rex   = reg_a.always_rex || rm_a.always_rex || r || b || w;
            if (rex && (reg_a.never_rex || rm_a.never_rex))
                err = ERR_REX;
        end
        else
        begin
            if (!(idx_a.mem_ok || idx_a.is_none) ||
                !(rm_a.mem_ok || rm_a.is_none || rm_a.is_rip))
                err = ERR_NOT_MEM;
            else if (rm_a.is_none)
                err = ERR_NO_BASE;
            else if (rm_a.is_rip)
            begin
                if (!idx_a.is_none || scale_multiplier != 8'd1)
                    err = ERR_RIP_INDEX;
                else
                begin
                    dcode = DISP_32;
                    modrm = {2'b00, reg_a.low3, RM_DISP};
                end
            end
            else if (!need_sib)
            begin
                dcode = dcode_mem;
                modrm = {dcode_mem, reg_a.low3, rm_a.low3};
            end
            else if (idx_a.is_sp_idx)
                err = ERR_RSP_INDEX;
            else if (!ss_ok)
                err = ERR_SCALE;
            else
            begin
                dcode = dcode_mem;
                sib   = {ss, (idx_a.is_none ? SIB_NO_INDEX : idx_a.low3), rm_a.low3};
                sibp  = 1'b1;
                modrm = {dcode_mem, reg_a.low3, RM_SIB};
            end
            w   = (reg_a.typ == TYPE_QWORD);
            x   = idx_a.rex_bit;
            rex = reg_a.always_rex || w || b || x || r;
            if (err == ERR_OK)
            begin
                if (!idx_a.is_none && (idx_a.typ != rm_a.typ))
                    err = ERR_TYPE;
                else if (rex && reg_a.never_rex)
                    err = ERR_REX;
            end
        end
    end

    // Drop all fields on error
    always_comb
    begin
        result.error_code = err;
        if (err != ERR_OK)
        begin
            result.modrm_byte      = 8'd0;
            result.sib_present     = 1'b0;
            result.sib_byte        = 8'd0;
            result.rex_present     = 1'b0;
            result.rex_byte        = REX_BASE;
            result.disp_bytes_code = DISP_NONE;
        end
        else
        begin
            result.modrm_byte      = modrm;
            result.sib_present     = sibp;
            result.sib_byte        = sib;
            result.rex_present     = rex;
            result.rex_byte        = REX_BASE | {3'b000, w, r, x, b};
            result.disp_bytes_code = dcode;
        end
    end

endmodule

// ===== design/x86_64_modrm_sib_rex_encoder_core.sv =====
// Channel | Signals                                     | Direction
// in      | in_valid, in_ready, opcode .. displacement  | operand word in
// out     | out_valid, out_ready, error_code .. disp    | encoded word out
//
// One word per cycle sustained while out_ready stays high; a taken word is registered in the input
// stage and then in the result stage, where out_valid rises for it unless the output is stalled.
// The encode is a single pass of table lookup and selection between the input
// register and the result register.
// Reset (rst_n low, asynchronous) empties both stages; no payload is cleared.
// A stalled output holds its word; the input stage still fills behind it.
`include "x86_64_modrm_sib_rex_encoder_core_macros.svh"

module x86_64_modrm_sib_rex_encoder_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               opcode,
    input  logic signed [8:0]  reg_code,
    input  logic signed [8:0]  rm_code,
    input  logic signed [8:0]  index_code,
    input  logic [7:0]         scale_multiplier,
    input  logic signed [31:0] displacement,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [2:0]         error_code,
    output logic [7:0]         modrm_byte,
    output logic               sib_present,
    output logic [7:0]         sib_byte,
    output logic               rex_present,
    output logic [6:0]         rex_byte,
    output logic [1:0]         disp_bytes_code
);
    import x86enc_pkg::*;

    logic               in_valid_reg;
    logic               in_valid_next;
    logic               opcode_reg;
    logic signed [8:0]  reg_code_reg;
    logic signed [8:0]  rm_code_reg;
    logic signed [8:0]  index_code_reg;
    logic [7:0]         scale_reg;
    logic signed [31:0] disp_reg;
    logic               out_valid_reg;
    logic               out_valid_next;
    enc_result_t        result_reg;
    enc_result_t        result_next;
    logic               advance;
    reg_attr_t          reg_a;
    reg_attr_t          rm_a;
    reg_attr_t          idx_a;

    // Move a word on when the result stage is free or being emptied
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_valid && in_ready)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    // Hold stage valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the incoming operand word
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            opcode_reg     <= opcode;
            reg_code_reg   <= reg_code;
            rm_code_reg    <= rm_code;
            index_code_reg <= index_code;
            scale_reg      <= scale_multiplier;
            disp_reg       <= displacement;
        end
    end

    // Decode the three register codes
    x86enc_attr u_attr_reg (
        .code (reg_code_reg),
        .attr (reg_a)
    );

    x86enc_attr u_attr_rm (
        .code (rm_code_reg),
        .attr (rm_a)
    );

    x86enc_attr u_attr_idx (
        .code (index_code_reg),
        .attr (idx_a)
    );

    x86enc_encode u_encode (
        .opcode           (opcode_reg),
        .reg_a            (reg_a),
        .rm_a             (rm_a),
        .idx_a            (idx_a),
        .scale_multiplier (scale_reg),
        .displacement     (disp_reg),
        .result           (result_next)
    );

    // Capture the encoded word
    always_ff @(posedge clk)
    begin
        if (advance)
            result_reg <= result_next;
    end

    assign out_valid       = out_valid_reg;
    assign error_code      = result_reg.error_code;
    assign modrm_byte      = result_reg.modrm_byte;
    assign sib_present     = result_reg.sib_present;
    assign sib_byte        = result_reg.sib_byte;
    assign rex_present     = result_reg.rex_present;
    assign rex_byte        = result_reg.rex_byte;
    assign disp_bytes_code = result_reg.disp_bytes_code;

    // Checks on the encoder's own logic
    `X86ENC_ASSERT_IMP(a_err_clears, out_valid && error_code != ERR_OK,
        modrm_byte == 8'd0 && !sib_present && !rex_present &&
        rex_byte == REX_BASE && disp_bytes_code == DISP_NONE,
        "error word carries fields")
    `X86ENC_ASSERT_IMP(a_sib_zero, out_valid && !sib_present,
        sib_byte == 8'd0, "sib byte set without sib")
    `X86ENC_ASSERT_IMP(a_rex_bits, out_valid && !rex_present,
        rex_byte == REX_BASE, "rex bits set without rex")
    `X86ENC_ASSERT_NXT(a_advance_fills, advance, out_valid, "advanced word not presented")

endmodule
